// ----- sv/tc_pkg.sv -----
// tc_pkg: shared widths, types and limits for the tetrahedron circumcentre pipeline
// no dependencies; compile first
package tc_pkg;

    localparam int IN_W      = 24;
    localparam int OUT_W     = 48;
    localparam int QUO_W     = OUT_W;
    localparam int MUL_CHUNK = 24;

    typedef logic signed [IN_W-1:0]  coord_t;
    typedef logic signed [OUT_W-1:0] center_t;

    localparam logic [QUO_W-1:0] POS_LIM = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] NEG_LIM = {1'b1, {(QUO_W-1){1'b0}}};

endpackage

// ----- sv/tc_if.sv -----
// tc_if: valid/ready channels carrying the vertex set and the circumcentre result
// depends on tc_pkg
interface tc_in_if;
    import tc_pkg::*;
    logic   valid;
    logic   ready;
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    coord_t dx;
    coord_t dy;
    coord_t dz;

    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz,
                    input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz,
                    output ready);
endinterface

interface tc_out_if;
    import tc_pkg::*;
    logic    valid;
    logic    ready;
    center_t center_x;
    center_t center_y;
    center_t center_z;
    logic    degenerate;
    logic    overflow;

    modport source (output valid, center_x, center_y, center_z, degenerate, overflow,
                    input ready);
    modport sink   (input valid, center_x, center_y, center_z, degenerate, overflow,
                    output ready);
endinterface

// ----- sv/tc_mul.sv -----
// tc_mul: three-stage signed multiplier built from chunk partial products
// depends on tc_pkg (chunk width)
module tc_mul import tc_pkg::*;
#(
    parameter int A_W = 25,
    parameter int B_W = 25
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [A_W-1:0]       a,
    input  logic signed [B_W-1:0]       b,
    output logic signed [A_W+B_W-1:0]   p
);

    localparam int NA  = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB  = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int EW  = (NA + NB) * MUL_CHUNK + 2;
    localparam int PPW = 2 * MUL_CHUNK + 2;

    logic signed [NA*MUL_CHUNK-1:0] a_ext;
    logic signed [NB*MUL_CHUNK-1:0] b_ext;
    logic signed [MUL_CHUNK:0]      a_part [NA];
    logic signed [MUL_CHUNK:0]      b_part [NB];
    logic signed [PPW-1:0]          pp_reg [NA][NB];
    logic signed [EW-1:0]           row_next [NA];
    logic signed [EW-1:0]           row_reg [NA];
    logic signed [EW-1:0]           sum_next;
    logic signed [EW-1:0]           p_reg;

    assign a_ext = (NA*MUL_CHUNK)'(a);
    assign b_ext = (NB*MUL_CHUNK)'(b);

    // low chunks unsigned, top chunk carries the sign
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            if (i == NA - 1)
                a_part[i] = {a_ext[i*MUL_CHUNK+MUL_CHUNK-1], a_ext[i*MUL_CHUNK +: MUL_CHUNK]};
            else
                a_part[i] = {1'b0, a_ext[i*MUL_CHUNK +: MUL_CHUNK]};
        end
        for (int j = 0; j < NB; j++)
        begin
            if (j == NB - 1)
                b_part[j] = {b_ext[j*MUL_CHUNK+MUL_CHUNK-1], b_ext[j*MUL_CHUNK +: MUL_CHUNK]};
            else
                b_part[j] = {1'b0, b_ext[j*MUL_CHUNK +: MUL_CHUNK]};
        end
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
                row_next[i] = row_next[i] + (EW'(pp_reg[i][j]) <<< (j * MUL_CHUNK));
        end
        sum_next = '0;
        for (int i = 0; i < NA; i++)
            sum_next = sum_next + (row_reg[i] <<< (i * MUL_CHUNK));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                    pp_reg[i][j] <= a_part[i] * b_part[j];
                row_reg[i] <= row_next[i];
            end
            p_reg <= sum_next;
        end
    end

    assign p = p_reg[A_W+B_W-1:0];

endmodule

// ----- sv/tc_div.sv -----
// tc_div: pipelined restoring divider, one quotient bit per stage, with range precheck
// depends on tc_pkg (quotient width)
module tc_div import tc_pkg::*;
#(
    parameter int NUM_W = 122,
    parameter int DEN_W = 79
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic [QUO_W-1:0]  quo,
    output logic              big
);

    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0] rem_reg [QUO_W+1];
    logic [QUO_W-1:0] low_reg [QUO_W+1];
    logic [QUO_W-1:0] quo_reg [QUO_W+1];
    logic [DEN_W-1:0] den_reg [QUO_W+1];
    logic             big_reg [QUO_W+1];
    logic [DEN_W:0]   trial   [QUO_W+1];
    logic [QUO_W:0]   ge;

    always_comb
    begin
        trial[0] = '0;
        ge[0]    = 1'b0;
        for (int k = 1; k <= QUO_W; k++)
        begin
            trial[k] = {rem_reg[k-1], low_reg[k-1][QUO_W-1]};
            ge[k]    = trial[k] >= {1'b0, den_reg[k-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient of 2^QUO_W or more means out of range
            rem_reg[0] <= DEN_W'(num[NUM_W-1:QUO_W]);
            low_reg[0] <= num[QUO_W-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            big_reg[0] <= CMP_W'(num[NUM_W-1:QUO_W]) >= CMP_W'(den);
            for (int k = 1; k <= QUO_W; k++)
            begin
                rem_reg[k] <= ge[k] ? DEN_W'(trial[k] - {1'b0, den_reg[k-1]})
                                    : DEN_W'(trial[k]);
                low_reg[k] <= low_reg[k-1] << 1;
                quo_reg[k] <= {quo_reg[k-1][QUO_W-2:0], ge[k]};
                den_reg[k] <= den_reg[k-1];
                big_reg[k] <= big_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[QUO_W];
    assign big = big_reg[QUO_W];

endmodule

// ----- sv/tetrahedron_circumcenter.sv -----
// tetrahedron_circumcenter: pipelined circumcentre of the four input vertices
// throughput one tetrahedron per cycle while the output is not stalled; the divider sets the depth
// a stalled output freezes every stage, nothing is lost or repeated
// reset clears the valid bits only; payload registers are not reset
module tetrahedron_circumcenter import tc_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    tc_in_if.sink    points,
    tc_out_if.source result
);

    localparam int C    = COORD_BITS;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * DW;
    localparam int XW   = PW + 1;
    localparam int SW   = PW + 2;
    localparam int TW   = DW + XW + 2;
    localparam int DENW = TW + 1;
    localparam int NTW  = SW + XW;
    localparam int NSW  = NTW + 2;
    localparam int DDW  = C + DENW;
    localparam int NUW  = ((NSW > DDW) ? NSW : DDW) + 1;
    localparam int NFW  = NUW + FRAC_BITS;
    localparam int LAT  = 16 + QUO_W;

    logic              en;
    logic [LAT:1]      vld_reg;

    logic [31:0]         raw    [12];
    logic signed [C-1:0] crd    [12];
    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] v_reg [3];
    logic signed [DW-1:0] w_reg [3];
    logic signed [C-1:0]  d_reg [3];
    logic signed [DW-1:0] u_dly_reg [4][3];
    logic signed [C-1:0]  d_dly_reg [8][3];

    logic signed [DW-1:0] ma_a [27];
    logic signed [DW-1:0] ma_b [27];
    logic signed [PW-1:0] ma_p [27];

    logic signed [XW-1:0] vw_reg [3];
    logic signed [XW-1:0] wu_reg [3];
    logic signed [XW-1:0] uv_reg [3];
    logic signed [SW-1:0] su_reg;
    logic signed [SW-1:0] sv_reg;
    logic signed [SW-1:0] sw_reg;

    logic signed [SW-1:0]     mn_a [9];
    logic signed [XW-1:0]     mn_b [9];
    logic signed [NTW-1:0]    mn_p [9];
    logic signed [DW+XW-1:0]  mt_p [3];

    logic signed [TW-1:0]   t_reg;
    logic signed [NSW-1:0]  n_reg [3];
    logic signed [TW-1:0]   t_dly_reg [3];
    logic signed [NSW-1:0]  n_dly_reg [3][3];
    logic signed [DENW-1:0] den9;
    logic signed [DDW-1:0]  dd_p [3];

    logic signed [NFW-1:0]  num_reg [3];
    logic signed [DENW-1:0] den_reg;
    logic [NFW-1:0]         nabs_reg [3];
    logic [DENW-1:0]        dabs_reg;
    logic                   neg_reg [3];
    logic                   deg_reg;
    logic                   neg_dly_reg [QUO_W+1][3];
    logic                   deg_dly_reg [QUO_W+1];

    logic [QUO_W-1:0]       quo [3];
    logic                   big [3];
    logic [QUO_W-1:0]       val_next [3];
    logic                   sat_next [3];

    center_t                cx_reg;
    center_t                cy_reg;
    center_t                cz_reg;
    logic                   deg_out_reg;
    logic                   ovf_out_reg;

    assign en           = !vld_reg[LAT] || result.ready;
    assign points.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-1:1], points.valid};
    end

    // only the low COORD_BITS bits of each field count
    always_comb
    begin
        raw[0]  = 32'($unsigned(points.ax));
        raw[1]  = 32'($unsigned(points.ay));
        raw[2]  = 32'($unsigned(points.az));
        raw[3]  = 32'($unsigned(points.bx));
        raw[4]  = 32'($unsigned(points.by));
        raw[5]  = 32'($unsigned(points.bz));
        raw[6]  = 32'($unsigned(points.cx));
        raw[7]  = 32'($unsigned(points.cy));
        raw[8]  = 32'($unsigned(points.cz));
        raw[9]  = 32'($unsigned(points.dx));
        raw[10] = 32'($unsigned(points.dy));
        raw[11] = 32'($unsigned(points.dz));
        for (int i = 0; i < 12; i++)
            crd[i] = raw[i][C-1:0];
    end

    // edge vectors against vertex d
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= DW'(crd[i])     - DW'(crd[9+i]);
                v_reg[i] <= DW'(crd[3+i])   - DW'(crd[9+i]);
                w_reg[i] <= DW'(crd[6+i])   - DW'(crd[9+i]);
                d_reg[i] <= crd[9+i];
                u_dly_reg[0][i] <= u_reg[i];
                d_dly_reg[0][i] <= d_reg[i];
            end
            for (int k = 1; k < 4; k++)
                u_dly_reg[k] <= u_dly_reg[k-1];
            for (int k = 1; k < 8; k++)
                d_dly_reg[k] <= d_dly_reg[k-1];
        end
    end

    // cross product terms and squared lengths
    always_comb
    begin
        int j;
        int k;
        for (int i = 0; i < 3; i++)
        begin
            j = (i == 2) ? 0 : i + 1;
            k = (i == 0) ? 2 : i - 1;
            ma_a[6*i]   = v_reg[j];  ma_b[6*i]   = w_reg[k];
            ma_a[6*i+1] = v_reg[k];  ma_b[6*i+1] = w_reg[j];
            ma_a[6*i+2] = w_reg[j];  ma_b[6*i+2] = u_reg[k];
            ma_a[6*i+3] = w_reg[k];  ma_b[6*i+3] = u_reg[j];
            ma_a[6*i+4] = u_reg[j];  ma_b[6*i+4] = v_reg[k];
            ma_a[6*i+5] = u_reg[k];  ma_b[6*i+5] = v_reg[j];
            ma_a[18+i]  = u_reg[i];  ma_b[18+i]  = u_reg[i];
            ma_a[21+i]  = v_reg[i];  ma_b[21+i]  = v_reg[i];
            ma_a[24+i]  = w_reg[i];  ma_b[24+i]  = w_reg[i];
        end
    end

    for (genvar g = 0; g < 27; g++)
    begin : g_mula
        tc_mul #(.A_W(DW), .B_W(DW)) u_mul
        (
            .clk (clk),
            .en  (en),
            .a   (ma_a[g]),
            .b   (ma_b[g]),
            .p   (ma_p[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vw_reg[i] <= XW'(ma_p[6*i])   - XW'(ma_p[6*i+1]);
                wu_reg[i] <= XW'(ma_p[6*i+2]) - XW'(ma_p[6*i+3]);
                uv_reg[i] <= XW'(ma_p[6*i+4]) - XW'(ma_p[6*i+5]);
            end
            su_reg <= SW'(ma_p[18]) + SW'(ma_p[19]) + SW'(ma_p[20]);
            sv_reg <= SW'(ma_p[21]) + SW'(ma_p[22]) + SW'(ma_p[23]);
            sw_reg <= SW'(ma_p[24]) + SW'(ma_p[25]) + SW'(ma_p[26]);
        end
    end

    // triple product terms and weighted normal terms
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mn_a[3*i]   = su_reg;  mn_b[3*i]   = vw_reg[i];
            mn_a[3*i+1] = sv_reg;  mn_b[3*i+1] = wu_reg[i];
            mn_a[3*i+2] = sw_reg;  mn_b[3*i+2] = uv_reg[i];
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_mult
        tc_mul #(.A_W(DW), .B_W(XW)) u_mul
        (
            .clk (clk),
            .en  (en),
            .a   (u_dly_reg[3][g]),
            .b   (vw_reg[g]),
            .p   (mt_p[g])
        );
    end

    for (genvar g = 0; g < 9; g++)
    begin : g_muln
        tc_mul #(.A_W(SW), .B_W(XW)) u_mul
        (
            .clk (clk),
            .en  (en),
            .a   (mn_a[g]),
            .b   (mn_b[g]),
            .p   (mn_p[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg <= TW'(mt_p[0]) + TW'(mt_p[1]) + TW'(mt_p[2]);
            for (int i = 0; i < 3; i++)
                n_reg[i] <= NSW'(mn_p[3*i]) + NSW'(mn_p[3*i+1]) + NSW'(mn_p[3*i+2]);
            t_dly_reg[0] <= t_reg;
            n_dly_reg[0] <= n_reg;
            for (int k = 1; k < 3; k++)
            begin
                t_dly_reg[k] <= t_dly_reg[k-1];
                n_dly_reg[k] <= n_dly_reg[k-1];
            end
        end
    end

    assign den9 = DENW'(t_reg) <<< 1;

    // vertex d scaled by the denominator
    for (genvar g = 0; g < 3; g++)
    begin : g_muld
        tc_mul #(.A_W(C), .B_W(DENW)) u_mul
        (
            .clk (clk),
            .en  (en),
            .a   (d_dly_reg[7][g]),
            .b   (den9),
            .p   (dd_p[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i]  <= NFW'(NUW'(n_dly_reg[2][i]) + NUW'(dd_p[i])) <<< FRAC_BITS;
                nabs_reg[i] <= num_reg[i][NFW-1] ? NFW'(-num_reg[i]) : NFW'(num_reg[i]);
                neg_reg[i]  <= num_reg[i][NFW-1] ^ den_reg[DENW-1];
            end
            den_reg  <= DENW'(t_dly_reg[2]) <<< 1;
            dabs_reg <= den_reg[DENW-1] ? DENW'(-den_reg) : DENW'(den_reg);
            deg_reg  <= den_reg == '0;
            neg_dly_reg[0] <= neg_reg;
            deg_dly_reg[0] <= deg_reg;
            for (int k = 1; k <= QUO_W; k++)
            begin
                neg_dly_reg[k] <= neg_dly_reg[k-1];
                deg_dly_reg[k] <= deg_dly_reg[k-1];
            end
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        tc_div #(.NUM_W(NFW), .DEN_W(DENW)) u_div
        (
            .clk (clk),
            .en  (en),
            .num (nabs_reg[g]),
            .den (dabs_reg),
            .quo (quo[g]),
            .big (big[g])
        );
    end

    // saturate and restore sign
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sat_next[i] = big[i] || (quo[i] > (neg_dly_reg[QUO_W][i] ? NEG_LIM : POS_LIM));
            if (sat_next[i])
                val_next[i] = neg_dly_reg[QUO_W][i] ? NEG_LIM : POS_LIM;
            else
                val_next[i] = neg_dly_reg[QUO_W][i] ? -quo[i] : quo[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (deg_dly_reg[QUO_W])
            begin
                cx_reg      <= '0;
                cy_reg      <= '0;
                cz_reg      <= '0;
                deg_out_reg <= 1'b1;
                ovf_out_reg <= 1'b0;
            end
            else
            begin
                cx_reg      <= val_next[0];
                cy_reg      <= val_next[1];
                cz_reg      <= val_next[2];
                deg_out_reg <= 1'b0;
                ovf_out_reg <= sat_next[0] || sat_next[1] || sat_next[2];
            end
        end
    end

    assign result.valid      = vld_reg[LAT];
    assign result.center_x   = cx_reg;
    assign result.center_y   = cy_reg;
    assign result.center_z   = cz_reg;
    assign result.degenerate = deg_out_reg;
    assign result.overflow   = ovf_out_reg;

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.degenerate |->
            result.center_x == '0 && result.center_y == '0 &&
            result.center_z == '0 && !result.overflow)
        else $error("degenerate result with nonzero fields");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        points.valid && points.ready |=> vld_reg[1])
        else $error("input transfer not entered into pipeline");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule
